// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL of the link sequence check.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

// ===== rtl/core/pslic_pkg.sv =====
// Types and constants of the per-link sequence integrity check.
// No dependencies; imported by the top level and by pslic_judge.
`default_nettype none
package pslic_pkg;

    // Table geometry: one entry per virtual link
    localparam int LINK_COUNT = 4096;
    localparam int ADDR_W     = $clog2(LINK_COUNT);
    localparam int VL_W       = 12;
    localparam int SEQ_W      = 8;

    // Sequence numbers with a special meaning
    localparam logic [SEQ_W-1:0] SEQ_RESET = 8'd0;
    localparam logic [SEQ_W-1:0] SEQ_FIRST = 8'd1;
    localparam logic [SEQ_W-1:0] SEQ_SECOND = 8'd2;
    localparam logic [SEQ_W-1:0] SEQ_TOP  = 8'd255;
    localparam logic [SEQ_W-1:0] SEQ_NEAR = 8'd254;

    // Input word: one received frame header
    typedef struct packed {
        logic [VL_W-1:0]  vl_index;
        logic [SEQ_W-1:0] seq_num;
    } frame_t;

    // Result word: verdict on one frame
    typedef struct packed {
        logic             pass;
        logic [VL_W-1:0]  vl_out;
        logic [SEQ_W-1:0] seq_out;
    } verdict_t;

    // One table entry per link
    typedef struct packed {
        logic             seen;
        logic [SEQ_W-1:0] last_seq;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage
`default_nettype wire

// ===== rtl/core/per_link_sequence_integrity_check.sv =====
// Top level of the per-link sequence integrity check: control, link table, judgment.
// Depends on pslic_pkg, pslic_ram, pslic_judge and assert_macros.svh.
//
//  Channel  | Handshake                 | Word
//  ---------+---------------------------+---------------------------------
//  frame    | start && !busy            | vl_index, seq_num
//  result   | done (one-cycle strobe)   | pass, vl_out, seq_out
//
// A frame's link entry is read from the table RAM in the accept cycle and
// judged and written back in the next; the result strobe follows in the
// cycle after that, while busy is already low again.
// After reset the table is swept clean, one entry a cycle, over all
// LINK_COUNT (4096) entries; busy stays high and no frame is taken until it ends.
// The receiver cannot stall; each result is valid for the single done cycle.
`default_nettype none
`include "assert_macros.svh"
module per_link_sequence_integrity_check (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire pslic_pkg::frame_t frame,
    output logic                   done,
    output pslic_pkg::verdict_t    result
);
    import pslic_pkg::*;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic [ADDR_W-1:0] clr_addr_next;
    frame_t            item_reg;
    frame_t            item_next;
    verdict_t          result_reg;
    verdict_t          result_next;
    logic              done_reg;
    logic              done_next;

    logic              accept;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    entry_t            wr_data;
    entry_t            rd_data;
    logic [ENTRY_W-1:0] rd_bits;
    logic              pass;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;
    assign rd_data = entry_t'(rd_bits);

    // Table write: zero entries while clearing, store the new number on lookup
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = clr_addr_reg;
        wr_data = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                wr_en = 1'b1;
            end
            ST_LOOKUP:
            begin
                wr_en            = 1'b1;
                wr_addr          = item_reg.vl_index[ADDR_W-1:0];
                wr_data.seen     = 1'b1;
                wr_data.last_seq = item_reg.seq_num;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    pslic_ram #(
        .DEPTH  (LINK_COUNT),
        .WIDTH  (ENTRY_W),
        .ADDR_W (ADDR_W)
    ) u_table (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (accept),
        .raddr (frame.vl_index[ADDR_W-1:0]),
        .rdata (rd_bits)
    );

    pslic_judge u_judge (
        .entry   (rd_data),
        .seq_num (item_reg.seq_num),
        .pass    (pass)
    );

    // Next state: sweep, wait for a frame, judge it
    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        item_next     = item_reg;
        result_next   = result_reg;
        done_next     = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == ADDR_W'(LINK_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    item_next  = frame;
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                result_next.pass    = pass;
                result_next.vl_out  = item_reg.vl_index;
                result_next.seq_out = item_reg.seq_num;
                done_next           = 1'b1;
                state_next          = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            item_reg     <= '0;
            result_reg   <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            item_reg     <= item_next;
            result_reg   <= result_next;
            done_reg     <= done_next;
        end
    end

    // Checks
    `ASSERT_CLK(a_accept_gives_result, clk, rst_n,
        (start && !busy) |-> ##2 done,
        "no result two cycles after accept")
    `ASSERT_NEVER(a_done_while_busy, clk, rst_n, done && busy, "result strobe while busy")
    `ASSERT_CLK(a_lookup_marks_seen, clk, rst_n,
        (state_reg == ST_LOOKUP) |-> (wr_en && wr_data.seen),
        "lookup without seen write-back")
    `ASSERT_CLK(a_result_echoes_item, clk, rst_n,
        done |-> ((result.vl_out == item_reg.vl_index) &&
                  (result.seq_out == item_reg.seq_num)),
        "result does not echo frame")

endmodule
`default_nettype wire

// ===== rtl/core/pslic_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none
module pslic_ram #(
    parameter int DEPTH  = 4096,
    parameter int WIDTH  = 9,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port: registered read data, updated only while re is high
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/pslic_judge.sv =====
// Sequence judgment: decides whether a frame number follows the stored link entry.
// Depends on pslic_pkg.
`default_nettype none
module pslic_judge (
    input  wire pslic_pkg::entry_t      entry,
    input  wire logic [pslic_pkg::SEQ_W-1:0] seq_num,
    output logic                        pass
);
    import pslic_pkg::*;

    logic [SEQ_W-1:0] next1;
    logic [SEQ_W-1:0] next2;

    // Expected successors, skipping zero on wrap
    always_comb
    begin
        if (entry.last_seq == SEQ_TOP)
        begin
            next1 = SEQ_FIRST;
            next2 = SEQ_SECOND;
        end
        else if (entry.last_seq == SEQ_NEAR)
        begin
            next1 = SEQ_TOP;
            next2 = SEQ_FIRST;
        end
        else
        begin
            next1 = entry.last_seq + SEQ_FIRST;
            next2 = entry.last_seq + SEQ_SECOND;
        end
    end

    // Verdict: first frame, sender reset, or one of two successors
    always_comb
    begin
        if (!entry.seen)
        begin
            pass = (seq_num == SEQ_RESET) || (seq_num == SEQ_FIRST);
        end
        else if ((entry.last_seq != SEQ_RESET) && (seq_num == SEQ_RESET))
        begin
            pass = 1'b1;
        end
        else
        begin
            pass = (seq_num == next1) || (seq_num == next2);
        end
    end

endmodule
`default_nettype wire
